@@ rtl/core/nine_slice_pixel_source_map_macros.svh @@
// Assertion macros shared by the nine-slice source map checker.
`ifndef NINE_SLICE_PIXEL_SOURCE_MAP_MACROS_SVH
`define NINE_SLICE_PIXEL_SOURCE_MAP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NSPSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NSPSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nspsm_pkg.sv @@
// Types, register codes and helper functions for the nine-slice source map.
package nspsm_pkg;

    localparam int PosW   = 12;
    localparam int SizeW  = 13;
    localparam int CfgW   = 4;
    localparam int CoordW = 7;
    localparam int IdxW   = 14;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_EDGE_COLS  = 3'd0,
        REG_FILL_COLS  = 3'd1,
        REG_INNER_COLS = 3'd2,
        REG_EDGE_ROWS  = 3'd3,
        REG_FILL_ROWS  = 3'd4,
        REG_INNER_ROWS = 3'd5
    } t_reg_idx;

    // Segment widths of one axis
    typedef struct packed {
        logic [CfgW-1:0] edge_len;
        logic [CfgW-1:0] fill_len;
        logic [CfgW-1:0] inner_len;
    } t_axis_cfg;

    // Mapped bitmap coordinate of one axis plus its range check
    typedef struct packed {
        logic              ok;
        logic [CoordW-1:0] coord;
    } t_axis_res;

    // Four restoring steps of r mod f, trial shifts hi down to hi-3
    function automatic logic [PosW-1:0] rem_steps(input logic [PosW-1:0] r_in,
                                                  input logic [CfgW-1:0] f,
                                                  input int hi);
        logic [PosW-1:0] r;
        logic [15:0]     sub;
        r = r_in;
        for (int j = 0; j < 4; j++) begin
            sub = 16'(f) << (hi - j);
            if ({4'b0, r} >= sub) begin
                r = r - sub[PosW-1:0];
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/nspsm_axis.sv @@
// One axis of the nine-slice map: segment decode, pipelined tiling remainder.
module nspsm_axis #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                                 i_clk,
    input  logic [3:0]                           i_en,
    input  logic [nspsm_pkg::PosW-1:0]           i_pos,
    input  logic [nspsm_pkg::SizeW-1:0]          i_size,
    input  nspsm_pkg::t_axis_cfg                 i_cfg,
    output nspsm_pkg::t_axis_res                 o_res
);

    localparam logic [16:0] MaxSide = 17'(MAX_SIDE);

    logic [3:0]  w_e, w_f, w_in;
    logic [6:0]  w_min_side;
    logic [11:0] w_half;
    logic [4:0]  w_e_in;
    logic [11:0] w_s;
    logic [12:0] w_s_in;
    logic [12:0] w_se;
    logic [12:0] w_pos;
    logic [6:0]  w_base2;
    logic [12:0] w_diff;
    logic [11:0] n_rem;
    logic [6:0]  n_base;
    logic        n_ok;
    logic [11:0] w_rem_last;

    logic [11:0] r_s1_rem, r_s2_rem, r_s3_rem;
    logic [6:0]  r_s1_base, r_s2_base, r_s3_base;
    logic        r_s1_ok, r_s2_ok, r_s3_ok;
    logic [6:0]  r_s4_coord;
    logic        r_s4_ok;

    assign w_e  = i_cfg.edge_len;
    assign w_f  = i_cfg.fill_len;
    assign w_in = i_cfg.inner_len;

    // Segment bounds: first fill ends at max(size/2 - inner, edge)
    assign w_min_side = {2'b0, w_e, 1'b0} + {2'b0, w_f, 1'b0} + {3'b0, w_in};
    assign w_half     = i_size[12:1];
    assign w_e_in     = {1'b0, w_e} + {1'b0, w_in};
    assign w_s        = (w_half > {7'b0, w_e_in}) ? (w_half - {8'b0, w_in}) : {8'b0, w_e};
    assign w_s_in     = {1'b0, w_s} + {9'b0, w_in};
    assign w_se       = i_size - {9'b0, w_e};
    assign w_pos      = {1'b0, i_pos};
    assign w_base2    = (w_in != '0) ? ({3'b0, w_e} + {3'b0, w_f} + {3'b0, w_in})
                                     : {3'b0, w_e};

    // Pick segment: fixed segments give the coordinate, fills give an offset to reduce
    always_comb begin
        n_rem  = '0;
        n_base = '0;
        w_diff = '0;
        if (w_pos < {9'b0, w_e}) begin
            n_base = i_pos[6:0];
        end else if (w_pos < {1'b0, w_s}) begin
            w_diff = w_pos - {9'b0, w_e};
            n_base = {3'b0, w_e};
            n_rem  = w_diff[11:0];
        end else if (w_pos < w_s_in) begin
            w_diff = w_pos - {1'b0, w_s};
            n_base = {3'b0, w_e} + {3'b0, w_f} + w_diff[6:0];
        end else if (w_pos < w_se) begin
            w_diff = w_pos - w_s_in;
            n_base = w_base2;
            n_rem  = w_diff[11:0];
        end else begin
            w_diff = w_pos - w_se;
            n_base = w_base2 + {3'b0, w_f} + w_diff[6:0];
        end
        // zero fill width: every fill pixel takes offset zero
        if (w_f == '0) begin
            n_rem = '0;
        end
    end

    assign n_ok = ({4'b0, i_size} <= MaxSide) && (i_size >= {6'b0, w_min_side})
               && (w_pos < i_size);

    assign w_rem_last = nspsm_pkg::rem_steps(r_s3_rem, w_f, 3);

    // Stage registers: decode, then three slices of the remainder
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_rem  <= n_rem;
            r_s1_base <= n_base;
            r_s1_ok   <= n_ok;
        end
        if (i_en[1]) begin
            r_s2_rem  <= nspsm_pkg::rem_steps(r_s1_rem, w_f, 11);
            r_s2_base <= r_s1_base;
            r_s2_ok   <= r_s1_ok;
        end
        if (i_en[2]) begin
            r_s3_rem  <= nspsm_pkg::rem_steps(r_s2_rem, w_f, 7);
            r_s3_base <= r_s2_base;
            r_s3_ok   <= r_s2_ok;
        end
        if (i_en[3]) begin
            r_s4_coord <= r_s3_base + {3'b0, w_rem_last[3:0]};
            r_s4_ok    <= r_s3_ok;
        end
    end

    assign o_res.ok    = r_s4_ok;
    assign o_res.coord = r_s4_coord;

endmodule

@@ rtl/core/nine_slice_pixel_source_map.sv @@
// Nine-slice skin renderer: bitmap loads and per-pixel texel lookups, top level.
// Throughput: one request per cycle while results are taken; a stalled result backs
// up the pipeline. Loads and lookups share one RAM port at the last stage, in request
// order, and a load yields no result.
// Reset: control and configuration registers return to their defaults synchronously;
// the bitmap RAM is not cleared and holds garbage until loaded.
module nine_slice_pixel_source_map #(
    parameter int BITMAP_WORDS  = 256,
    parameter int MAX_RECT_SIDE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_word_index,
    input  logic [31:0] i_word_value,
    input  logic [11:0] i_pixel_col,
    input  logic [11:0] i_pixel_row,
    input  logic [12:0] i_rect_width,
    input  logic [12:0] i_rect_height,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_color,
    output logic [7:0]  o_texel_index,
    output logic        o_drawn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          AddrW = $clog2(BITMAP_WORDS);
    localparam logic [14:0] Words = 15'(BITMAP_WORDS);

    // configuration registers
    logic [3:0] r_edge_cols, r_fill_cols, r_inner_cols;
    logic [3:0] r_edge_rows, r_fill_rows, r_inner_rows;
    logic       w_cfg_wr;

    // pipeline control
    logic [6:1] r_vld;
    logic [6:1] w_en;

    // request payload carried to the RAM stage
    logic        r_act  [1:4];
    logic [7:0]  r_widx [1:4];
    logic [31:0] r_wval [1:4];

    nspsm_pkg::t_axis_cfg w_cfg_x, w_cfg_y;
    nspsm_pkg::t_axis_res w_res_x, w_res_y;

    // stage 5: texel index and RAM request
    logic [6:0]  w_cw;
    logic [13:0] w_idx;
    logic [15:0] w_idx_ext, w_widx_ext;
    logic        w_drawn;
    logic        r_s5_lookup, r_s5_drawn, r_s5_wen;
    logic [7:0]  r_s5_idx;
    logic [AddrW-1:0] r_s5_addr;
    logic [31:0] r_s5_wdata;

    // stage 6: result register
    logic [31:0] r_s6_color;
    logic        r_s6_drawn;
    logic [7:0]  r_s6_idx;

    logic [31:0] r_bitmap [BITMAP_WORDS];

    // Configuration write and readback
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cols  <= 4'd2;
            r_fill_cols  <= 4'd1;
            r_inner_cols <= 4'd0;
            r_edge_rows  <= 4'd2;
            r_fill_rows  <= 4'd1;
            r_inner_rows <= 4'd0;
        end else if (w_cfg_wr) begin
            case (nspsm_pkg::t_reg_idx'(paddr[4:2]))
                nspsm_pkg::REG_EDGE_COLS: begin
                    r_edge_cols <= pwdata[3:0];
                end
                nspsm_pkg::REG_FILL_COLS: begin
                    r_fill_cols <= pwdata[3:0];
                end
                nspsm_pkg::REG_INNER_COLS: begin
                    r_inner_cols <= pwdata[3:0];
                end
                nspsm_pkg::REG_EDGE_ROWS: begin
                    r_edge_rows <= pwdata[3:0];
                end
                nspsm_pkg::REG_FILL_ROWS: begin
                    r_fill_rows <= pwdata[3:0];
                end
                nspsm_pkg::REG_INNER_ROWS: begin
                    r_inner_rows <= pwdata[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (nspsm_pkg::t_reg_idx'(paddr[4:2]))
            nspsm_pkg::REG_EDGE_COLS:  prdata = {28'b0, r_edge_cols};
            nspsm_pkg::REG_FILL_COLS:  prdata = {28'b0, r_fill_cols};
            nspsm_pkg::REG_INNER_COLS: prdata = {28'b0, r_inner_cols};
            nspsm_pkg::REG_EDGE_ROWS:  prdata = {28'b0, r_edge_rows};
            nspsm_pkg::REG_FILL_ROWS:  prdata = {28'b0, r_fill_rows};
            nspsm_pkg::REG_INNER_ROWS: prdata = {28'b0, r_inner_rows};
            default:                   prdata = '0;
        endcase
    end

    // Stage enables: a stage moves when empty or when the one after it moves
    always_comb begin
        w_en[6] = !r_vld[6] || i_ready;
        for (int k = 5; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) r_vld[1] <= i_valid;
            for (int k = 2; k <= 5; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
            // loads end at the RAM stage
            if (w_en[6]) r_vld[6] <= r_vld[5] && r_s5_lookup;
        end
    end

    // Request payload shift line
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_act[1]  <= i_action;
            r_widx[1] <= i_word_index;
            r_wval[1] <= i_word_value;
        end
        for (int k = 2; k <= 4; k++) begin
            if (w_en[k]) begin
                r_act[k]  <= r_act[k-1];
                r_widx[k] <= r_widx[k-1];
                r_wval[k] <= r_wval[k-1];
            end
        end
    end

    // Per-axis coordinate pipelines (stages 1 to 4)
    assign w_cfg_x = '{edge_len: r_edge_cols, fill_len: r_fill_cols, inner_len: r_inner_cols};
    assign w_cfg_y = '{edge_len: r_edge_rows, fill_len: r_fill_rows, inner_len: r_inner_rows};

    nspsm_axis #(
        .MAX_SIDE (MAX_RECT_SIDE)
    ) u_axis_col (
        .i_clk  (i_clk),
        .i_en   (w_en[4:1]),
        .i_pos  (i_pixel_col),
        .i_size (i_rect_width),
        .i_cfg  (w_cfg_x),
        .o_res  (w_res_x)
    );

    nspsm_axis #(
        .MAX_SIDE (MAX_RECT_SIDE)
    ) u_axis_row (
        .i_clk  (i_clk),
        .i_en   (w_en[4:1]),
        .i_pos  (i_pixel_row),
        .i_size (i_rect_height),
        .i_cfg  (w_cfg_y),
        .o_res  (w_res_y)
    );

    // Linear texel index: row * bitmap width + column
    assign w_cw = {2'b0, r_edge_cols, 1'b0} + {3'b0, r_fill_cols} + {3'b0, r_inner_cols}
                + ((r_inner_cols != '0) ? {3'b0, r_fill_cols} : 7'd0);
    assign w_idx      = {7'b0, w_res_y.coord} * {7'b0, w_cw} + {7'b0, w_res_x.coord};
    assign w_idx_ext  = {2'b0, w_idx};
    assign w_widx_ext = {8'b0, r_widx[4]};
    assign w_drawn    = w_res_x.ok && w_res_y.ok && ({1'b0, w_idx} < Words);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_lookup <= r_act[4];
            r_s5_drawn  <= r_act[4] && w_drawn;
            r_s5_idx    <= (r_act[4] && w_drawn) ? w_idx[7:0] : 8'd0;
            r_s5_addr   <= r_act[4] ? w_idx_ext[AddrW-1:0] : w_widx_ext[AddrW-1:0];
            r_s5_wen    <= !r_act[4] && ({7'b0, r_widx[4]} < Words);
            r_s5_wdata  <= r_wval[4];
        end
    end

    // Bitmap RAM: one access per cycle when the RAM stage moves, write for loads, registered read for lookups
    always_ff @(posedge i_clk) begin
        if (w_en[6] && r_vld[5]) begin
            if (r_s5_wen) begin
                r_bitmap[r_s5_addr] <= r_s5_wdata;
            end
            r_s6_color <= r_bitmap[r_s5_addr];
            r_s6_drawn <= r_s5_drawn;
            r_s6_idx   <= r_s5_idx;
        end
    end

    assign o_valid       = r_vld[6];
    assign o_color       = r_s6_drawn ? r_s6_color : 32'd0;
    assign o_texel_index = r_s6_idx;
    assign o_drawn       = r_s6_drawn;

endmodule

@@ rtl/core/nspsm_checker.sv @@
// Port-level checker for the nine-slice source map, with its bind.
`include "nine_slice_pixel_source_map_macros.svh"

module nspsm_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_color,
    input logic [7:0]  o_texel_index,
    input logic        o_drawn,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a stalled result holds
    `NSPSM_ASSERT_NEXT(a_result_hold, o_valid && !i_ready, o_valid && $stable(o_color) && $stable(o_texel_index) && $stable(o_drawn), "stalled result changed")

    // a pixel that is not drawn reports zero color and index
    `NSPSM_ASSERT(a_undrawn_zero, o_valid && !o_drawn |-> o_color == 32'd0 && o_texel_index == 8'd0, "undrawn pixel has nonzero fields")

    // backpressure only when the pipeline is full behind a stalled result
    `NSPSM_ASSERT(a_ready_backpressure, !o_ready |-> o_valid && !i_ready, "request stalled with room in pipeline")

    // a written edge width reads back
    `NSPSM_ASSERT(a_cfg_readback, (psel && penable && pwrite && paddr[4:2] == nspsm_pkg::REG_EDGE_COLS) ##1 (paddr[4:2] == nspsm_pkg::REG_EDGE_COLS) |-> prdata == 32'($past(pwdata[3:0])), "edge width readback mismatch")

endmodule

bind nine_slice_pixel_source_map nspsm_assert u_nspsm_assert (.*);

@@ sim/nspsm_tb_pkg.sv @@
// Request codes shared by the nine-slice source map testbench files.
`timescale 1ns / 100ps

package nspsm_tb_pkg;

    // What one request asks the block to do
    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_pix_action;

endpackage

@@ sim/nspsm_checker.sv @@
// Watches the nine-slice source map channels, predicts each pixel lookup and compares results.
`timescale 1ns / 100ps

module nspsm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_action,
    input  logic [7:0]  i_word_index,
    input  logic [31:0] i_word_value,
    input  logic [11:0] i_pixel_col,
    input  logic [11:0] i_pixel_row,
    input  logic [12:0] i_rect_width,
    input  logic [12:0] i_rect_height,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_color,
    input  logic [7:0]  i_texel_index,
    input  logic        i_drawn,
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    // status toward the test top
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SkinWords = 256;
    localparam int MaxSide   = 4096;

    typedef struct {
        logic [31:0] color;
        logic [7:0]  texel_index;
        logic        drawn;
    } t_pixel_result;

    // Shadow of the bitmap and of the six skin registers
    logic [31:0]          bitmap_copy [SkinWords];
    nspsm_pkg::t_axis_cfg col_skin;
    nspsm_pkg::t_axis_cfg row_skin;

    t_pixel_result expected_pixels[$];
    t_pixel_result oldest;

    // Position inside a tiled fill; a zero-width fill always lands on its first texel
    function automatic int fill_phase(int d, int f);
        if (f <= 0) begin
            return 0;
        end
        return d % f;
    endfunction

    // Maps one axis position to a bitmap coordinate
    function automatic int skin_coord(int p, int size, nspsm_pkg::t_axis_cfg cfg);
        int e, f, inn, fill_end, split, second_end, base2;
        e          = int'(cfg.edge_len);
        f          = int'(cfg.fill_len);
        inn        = int'(cfg.inner_len);
        fill_end   = size / 2 - inn;
        split      = (fill_end > e) ? fill_end : e;
        second_end = size - e;
        base2      = (inn != 0) ? e + f + inn : e;
        if (p < e) begin
            return p;
        end
        if (p < split) begin
            return e + fill_phase(p - e, f);
        end
        if (p < split + inn) begin
            return e + f + (p - split);
        end
        if (p < second_end) begin
            return base2 + fill_phase(p - (split + inn), f);
        end
        return base2 + f + (p - second_end);
    endfunction

    // Expected answer for one pixel lookup under the current skin
    function automatic t_pixel_result lookup_texel(int col, int row, int w, int h);
        t_pixel_result res;
        int min_w, min_h, skin_w, tc, tr, idx;
        res.color       = '0;
        res.texel_index = '0;
        res.drawn       = 1'b0;
        min_w  = 2 * col_skin.edge_len + 2 * col_skin.fill_len + col_skin.inner_len;
        min_h  = 2 * row_skin.edge_len + 2 * row_skin.fill_len + row_skin.inner_len;
        skin_w = 2 * col_skin.edge_len + col_skin.fill_len + col_skin.inner_len
               + ((col_skin.inner_len != 0) ? col_skin.fill_len : 0);
        if (w > MaxSide || h > MaxSide) begin
            return res;
        end
        if (w < min_w || h < min_h) begin
            return res;
        end
        if (col >= w || row >= h) begin
            return res;
        end
        tc  = skin_coord(col, w, col_skin);
        tr  = skin_coord(row, h, row_skin);
        idx = tr * skin_w + tc;
        if (idx < 0 || idx >= SkinWords) begin
            return res;
        end
        res.color       = bitmap_copy[idx];
        res.texel_index = idx[7:0];
        res.drawn       = 1'b1;
        return res;
    endfunction

    // Track config writes, loads and lookups, and check each result in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            col_skin = '{edge_len: 4'd2, fill_len: 4'd1, inner_len: 4'd0};
            row_skin = '{edge_len: 4'd2, fill_len: 4'd1, inner_len: 4'd0};
            expected_pixels.delete();
        end else begin
            // result side first: a result never belongs to a request of this edge
            if (i_res_valid && i_res_ready) begin
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: result with none pending: color %h texel %0d drawn %0b",
                                 $realtime, i_color, i_texel_index, i_drawn);
                    end
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (i_color !== oldest.color || i_texel_index !== oldest.texel_index
                            || i_drawn !== oldest.drawn) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: pixel mismatch: expected color %h texel %0d drawn %0b,",
                                     $realtime, oldest.color, oldest.texel_index,
                                     oldest.drawn);
                            $display("        got color %h texel %0d drawn %0b",
                                     i_color, i_texel_index, i_drawn);
                        end
                    end
                end
            end

            // request side
            if (i_req_valid && i_req_ready) begin
                if (i_action == nspsm_tb_pkg::ACT_LOAD) begin
                    bitmap_copy[i_word_index] = i_word_value;
                end else begin
                    expected_pixels.push_back(lookup_texel(int'(i_pixel_col),
                        int'(i_pixel_row), int'(i_rect_width), int'(i_rect_height)));
                end
            end

            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (nspsm_pkg::t_reg_idx'(i_paddr[4:2]))
                    nspsm_pkg::REG_EDGE_COLS:  col_skin.edge_len  = i_pwdata[3:0];
                    nspsm_pkg::REG_FILL_COLS:  col_skin.fill_len  = i_pwdata[3:0];
                    nspsm_pkg::REG_INNER_COLS: col_skin.inner_len = i_pwdata[3:0];
                    nspsm_pkg::REG_EDGE_ROWS:  row_skin.edge_len  = i_pwdata[3:0];
                    nspsm_pkg::REG_FILL_ROWS:  row_skin.fill_len  = i_pwdata[3:0];
                    nspsm_pkg::REG_INNER_ROWS: row_skin.inner_len = i_pwdata[3:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_pixels.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

@@ sim/tb.sv @@
// Test top for the nine-slice source map: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        nspsm_tb_pkg::t_pix_action action;
        logic [7:0]  word_index;
        logic [31:0] word_value;
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [12:0] rect_width;
        logic [12:0] rect_height;
    } t_pixel_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [7:0]  i_word_index;
    logic [31:0] i_word_value;
    logic [11:0] i_pixel_col;
    logic [11:0] i_pixel_row;
    logic [12:0] i_rect_width;
    logic [12:0] i_rect_height;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_color;
    logic [7:0]  o_texel_index;
    logic        o_drawn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;

    // Stimulus shaping
    bit steady_send;
    bit long_hold_req;
    int burst_left;

    // Current skin, kept only to aim the random rectangles
    int col_edge, col_fill, col_inner;
    int row_edge, row_fill, row_inner;

    nine_slice_pixel_source_map DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_color       (o_color),
        .o_texel_index (o_texel_index),
        .o_drawn       (o_drawn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    nspsm_checker CHK (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_action      (i_action),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_color       (o_color),
        .i_texel_index (o_texel_index),
        .i_drawn       (o_drawn),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: stall pattern whose mode is picked at random from four, plus one long hold-off
    initial begin : result_sink
        int cyc;
        int mode;
        cyc     = 0;
        mode    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                if (cyc % 48 == 0) begin
                    mode = $urandom_range(0, 3);
                end
                cyc++;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 7) != 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_pixel_req load_req(int idx, logic [31:0] value);
        t_pixel_req r;
        r.action      = nspsm_tb_pkg::ACT_LOAD;
        r.word_index  = idx[7:0];
        r.word_value  = value;
        r.pixel_col   = 12'($urandom());
        r.pixel_row   = 12'($urandom());
        r.rect_width  = 13'($urandom());
        r.rect_height = 13'($urandom());
        return r;
    endfunction

    function automatic t_pixel_req lookup_req(int col, int row, int w, int h);
        t_pixel_req r;
        r.action      = nspsm_tb_pkg::ACT_LOOKUP;
        r.word_index  = 8'($urandom());
        r.word_value  = $urandom();
        r.pixel_col   = col[11:0];
        r.pixel_row   = row[11:0];
        r.rect_width  = w[12:0];
        r.rect_height = h[12:0];
        return r;
    endfunction

    // Rectangle side: mostly just above the minimum, sometimes huge, oversized or too small
    function automatic int pick_side(int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            return (min_len + 20 > 4096) ? 4096 : min_len + $urandom_range(0, 20);
        end
        if (r < 86) begin
            return $urandom_range(min_len, 4096);
        end
        if (r < 93) begin
            return $urandom_range(4097, 8191);
        end
        if (min_len > 0) begin
            return $urandom_range(0, min_len - 1);
        end
        return $urandom_range(0, 8191);
    endfunction

    // Pixel position: mostly inside the rectangle
    function automatic int pick_pos(int side);
        if ($urandom_range(0, 9) != 0 && side > 0) begin
            return $urandom_range(0, ((side > 4096) ? 4096 : side) - 1);
        end
        return $urandom_range(0, 4095);
    endfunction

    function automatic t_pixel_req random_req();
        int w, h;
        if ($urandom_range(0, 99) < 15) begin
            return load_req($urandom_range(0, 255), $urandom());
        end
        w = pick_side(2 * col_edge + 2 * col_fill + col_inner);
        h = pick_side(2 * row_edge + 2 * row_fill + row_inner);
        return lookup_req(pick_pos(w), pick_pos(h), w, h);
    endfunction

    // Offer one request and hold it until accepted; gaps come between bursts unless steady_send is set
    task automatic push_req(input t_pixel_req r);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_action      <= r.action;
        i_word_index  <= r.word_index;
        i_word_value  <= r.word_value;
        i_pixel_col   <= r.pixel_col;
        i_pixel_row   <= r.pixel_row;
        i_rect_width  <= r.rect_width;
        i_rect_height <= r.rect_height;
        do @(posedge i_clk); while (!o_ready);
        if (!steady_send) begin
            burst_left--;
            if (burst_left <= 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Stop sending and wait until every lookup has answered, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Register write: a setup phase, then an access phase held until pready
    task automatic cfg_write(input nspsm_pkg::t_reg_idx idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'h0, value[3:0]};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_skin(input int ce, input int cf, input int ci,
                              input int re, input int rf, input int ri);
        cfg_write(nspsm_pkg::REG_EDGE_COLS, ce);
        cfg_write(nspsm_pkg::REG_FILL_COLS, cf);
        cfg_write(nspsm_pkg::REG_INNER_COLS, ci);
        cfg_write(nspsm_pkg::REG_EDGE_ROWS, re);
        cfg_write(nspsm_pkg::REG_FILL_ROWS, rf);
        cfg_write(nspsm_pkg::REG_INNER_ROWS, ri);
        col_edge = ce; col_fill = cf; col_inner = ci;
        row_edge = re; row_fill = rf; row_inner = ri;
    endtask

    task automatic run_random(input int n);
        repeat (n) push_req(random_req());
        settle();
    endtask

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = nspsm_tb_pkg::ACT_LOAD;
        i_word_index  = '0;
        i_word_value  = '0;
        i_pixel_col   = '0;
        i_pixel_row   = '0;
        i_rect_width  = '0;
        i_rect_height = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady_send   = 1'b0;
        long_hold_req = 1'b0;
        burst_left    = 4;
        col_edge = 2; col_fill = 1; col_inner = 0;
        row_edge = 2; row_fill = 1; row_inner = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Skin 12x12 with inner blocks; the whole bitmap is loaded before any lookup
        apply_skin(2, 3, 2, 2, 3, 2);
        for (int k = 0; k < 256; k++) begin
            push_req(load_req(k, $urandom()));
        end

        // Directed: value extremes, size limits, pixels outside, every segment
        push_req(load_req(0, 32'h0000_0000));
        push_req(load_req(255, 32'hFFFF_FFFF));
        push_req(lookup_req(0, 0, 12, 12));
        push_req(lookup_req(11, 11, 12, 12));
        push_req(lookup_req(0, 0, 11, 12));
        push_req(lookup_req(0, 0, 12, 11));
        push_req(lookup_req(12, 0, 12, 12));
        push_req(lookup_req(0, 12, 12, 12));
        push_req(lookup_req(4095, 4095, 4096, 4096));
        push_req(lookup_req(2047, 2048, 4096, 4096));
        push_req(lookup_req(0, 0, 4097, 12));
        push_req(lookup_req(0, 0, 12, 8191));
        push_req(lookup_req(0, 0, 0, 0));
        push_req(lookup_req(5, 22, 40, 40));
        push_req(lookup_req(18, 38, 40, 40));
        push_req(lookup_req(19, 1, 40, 40));
        push_req(lookup_req(39, 5, 40, 40));
        push_req(lookup_req(22, 19, 40, 40));
        push_req(lookup_req(1, 39, 40, 40));
        run_random(40);

        // Reset skin with no inner block; result side holds off while requests keep coming
        apply_skin(2, 1, 0, 2, 1, 0);
        steady_send   = 1'b1;
        long_hold_req = 1'b1;
        run_random(40);
        steady_send = 1'b0;

        // Largest skin: many texels fall outside the bitmap
        apply_skin(15, 15, 15, 15, 15, 15);
        run_random(30);

        // Smallest skin
        apply_skin(0, 1, 0, 0, 1, 0);
        run_random(30);

        // Zero-width fill on both axes
        apply_skin(3, 0, 2, 1, 0, 0);
        run_random(30);

        // Lopsided skin, no gaps on the request side
        steady_send = 1'b1;
        apply_skin(0, 15, 0, 15, 0, 15);
        run_random(30);
        steady_send = 1'b0;

        // A few random small skins
        for (int k = 0; k < 3; k++) begin
            apply_skin($urandom_range(0, 4), $urandom_range(1, 5), $urandom_range(0, 4),
                       $urandom_range(0, 4), $urandom_range(1, 5), $urandom_range(0, 4));
            run_random(25);
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ nine_slice_pixel_source_map.f @@
+incdir+rtl/core
rtl/core/nspsm_pkg.sv
rtl/core/nspsm_axis.sv
rtl/core/nine_slice_pixel_source_map.sv
rtl/core/nspsm_checker.sv
sim/nspsm_tb_pkg.sv
sim/nspsm_checker.sv
sim/tb.sv
